### rtl/ostt_pkg.sv
// shared types and constants for the one-shot timer table
`default_nettype none

package ostt_pkg;

  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic [31:0] deadline;
    logic [15:0] handler;
    logic [31:0] arg;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

endpackage

`default_nettype wire

### rtl/ostt_ram.sv
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module ostt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [WIDTH-1:0]      wr_data,
  input  wire logic [AW-1:0]         rd_addr,
  output logic      [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/oneshot_software_timer_table_top.sv
// top level of the one-shot timer table: slot memory, tick counter and scan control
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | func, handler_id, callback_arg, timeout, slot_index
//  out_    | output    | out_valid / out_stall | status, slot, fired, fired_handler, fired_arg, tick_now
//
//  create, delete and unused codes go from the accepting cycle to ST_EMIT, which loads the result
//  a tick scans the slot memory, reading one slot entry per cycle, and stops at the first
//  expired timer
//  one transaction is in flight at a time; in_stall is high until its result is registered
//  reset zeroes the tick counter and frees every slot; slot memory contents are not cleared
//  a stalled result holds in the output register while the next transaction is taken
`default_nettype none

module oneshot_software_timer_table_top
  import ostt_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_handler_id,
  input  wire logic [31:0] in_callback_arg,
  input  wire logic [31:0] in_timeout,
  input  wire logic [3:0]  in_slot_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [3:0]       out_slot,
  output logic             out_fired,
  output logic [15:0]      out_fired_handler,
  output logic [31:0]      out_fired_arg,
  output logic [31:0]      out_tick_now
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t                 state_r;
  logic [NUM_SLOTS-1:0]   act_r;
  logic [31:0]            tick_r;
  logic [IDX_W-1:0]       scan_rd_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic                   cmp_vld_r;

  logic                   res_status_r;
  logic [3:0]             res_slot_r;
  logic                   res_fired_r;
  logic [15:0]            res_handler_r;
  logic [31:0]            res_arg_r;

  logic                   out_valid_r;
  logic                   out_status_r;
  logic [3:0]             out_slot_r;
  logic                   out_fired_r;
  logic [15:0]            out_handler_r;
  logic [31:0]            out_arg_r;
  logic [31:0]            out_tick_r;

  logic [IDX_W-1:0]       free_idx;
  logic                   create_ok;
  logic                   del_ok;
  logic [IDX_W-1:0]       del_idx;
  logic                   wr_en;
  ent_t                   wr_data;
  ent_t                   rd_data;
  logic                   hit;
  logic                   out_load;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign create_ok = (in_handler_id != 16'd0) && (in_timeout != 32'd0) && !(&act_r);
  assign del_ok    = 32'(in_slot_index) < 32'(NUM_SLOTS);
  assign del_idx   = IDX_W'(in_slot_index);

  assign in_stall = (state_r != ST_IDLE);
  assign wr_en    = in_valid && (state_r == ST_IDLE) && (in_func == FUNC_CREATE) && create_ok;

  always_comb begin
    wr_data.deadline = tick_r + in_timeout;
    wr_data.handler  = in_handler_id;
    wr_data.arg      = in_callback_arg;
  end

  ostt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (free_idx),
    .wr_data (wr_data),
    .rd_addr (scan_rd_r),
    .rd_data (rd_data)
  );

  assign hit      = cmp_vld_r && act_r[cmp_idx_r] && (rd_data.deadline <= tick_r);
  assign out_load = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      act_r       <= '0;
      tick_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_EMIT) && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            res_fired_r   <= 1'b0;
            res_handler_r <= 16'd0;
            res_arg_r     <= 32'd0;
            case (in_func)
              FUNC_CREATE: begin
                state_r <= ST_EMIT;
                if (create_ok) begin
                  act_r[free_idx] <= 1'b1;
                  res_status_r    <= STATUS_OK;
                  res_slot_r      <= 4'(free_idx);
                end else begin
                  res_status_r <= STATUS_REJECT;
                  res_slot_r   <= 4'd0;
                end
              end
              FUNC_DELETE: begin
                res_status_r <= STATUS_OK;
                res_slot_r   <= 4'd0;
                state_r      <= ST_EMIT;
                if (del_ok) begin
                  act_r[del_idx] <= 1'b0;
                end
              end
              FUNC_TICK: begin
                res_status_r <= STATUS_OK;
                res_slot_r   <= 4'd0;
                tick_r       <= tick_r + 32'd1;
                scan_rd_r    <= '0;
                cmp_vld_r    <= 1'b0;
                state_r      <= ST_SCAN;
              end
              default: begin
                res_status_r <= STATUS_OK;
                res_slot_r   <= 4'd0;
                state_r      <= ST_EMIT;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_rd_r != LAST_IDX) begin
            scan_rd_r <= scan_rd_r + 1'b1;
          end
          cmp_vld_r <= 1'b1;
          cmp_idx_r <= scan_rd_r;
          if (hit) begin
            act_r[cmp_idx_r] <= 1'b0;
            res_fired_r      <= 1'b1;
            res_slot_r       <= 4'(cmp_idx_r);
            res_handler_r    <= rd_data.handler;
            res_arg_r        <= rd_data.arg;
            state_r          <= ST_EMIT;
          end else if (cmp_vld_r && (cmp_idx_r == LAST_IDX)) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_status_r  <= res_status_r;
            out_slot_r    <= res_slot_r;
            out_fired_r   <= res_fired_r;
            out_handler_r <= res_handler_r;
            out_arg_r     <= res_arg_r;
            out_tick_r    <= tick_r;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_fired         = out_fired_r;
  assign out_fired_handler = out_handler_r;
  assign out_fired_arg     = out_arg_r;
  assign out_tick_now      = out_tick_r;

endmodule

`default_nettype wire

### rtl/ostt_chk.sv
// port-level checker for the one-shot timer table and its bind
`default_nettype none

module ostt_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_func,
  input wire logic [15:0] in_handler_id,
  input wire logic [31:0] in_callback_arg,
  input wire logic [31:0] in_timeout,
  input wire logic [3:0]  in_slot_index,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_status,
  input wire logic [3:0]  out_slot,
  input wire logic        out_fired,
  input wire logic [15:0] out_fired_handler,
  input wire logic [31:0] out_fired_arg,
  input wire logic [31:0] out_tick_now
);

  // stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable({out_status, out_slot, out_fired,
                                                     out_fired_handler, out_fired_arg,
                                                     out_tick_now}))
    else $error("result dropped or changed while stalled");

  // stalled input transaction stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable({in_func, in_handler_id, in_callback_arg,
                                                  in_timeout, in_slot_index}))
    else $error("input transaction dropped or changed while stalled");

  // one transaction in flight: an accepted transaction closes the input
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a transaction is in flight");

  // a rejected create reports no slot and no expiry
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_fired && (out_slot == 4'd0))
    else $error("rejected create carries slot or expiry");

  // an expired timer always has a handler, since zero handlers are rejected
  a_fired_handler: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fired |-> (out_fired_handler != 16'd0) && !out_status)
    else $error("expiry with empty handler");

endmodule

bind oneshot_software_timer_table_top ostt_chk u_ostt_chk (.*);

`default_nettype wire

### bench/ostt_checker.sv
// checker for the one-shot timer table: predicts every result and compares it field by field
module ostt_checker
  import ostt_pkg::*;
#(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [15:0] in_handler_id,
  input  logic [31:0] in_callback_arg,
  input  logic [31:0] in_timeout,
  input  logic [3:0]  in_slot_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_status,
  input  logic [3:0]  out_slot,
  input  logic        out_fired,
  input  logic [15:0] out_fired_handler,
  input  logic [31:0] out_fired_arg,
  input  logic [31:0] out_tick_now,
  output int          mismatch_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        status;
    logic [3:0]  slot;
    logic        fired;
    logic [15:0] fired_handler;
    logic [31:0] fired_arg;
    logic [31:0] tick_now;
  } timer_result_t;

  timer_result_t due_results[$];
  logic [31:0]   ticks;
  logic          slot_busy[NUM_SLOTS];
  ent_t          slot_ent[NUM_SLOTS];
  int            fail_tally = 0;

  initial begin
    mismatch_count = 0;
    outstanding = 0;
  end

  function automatic timer_result_t apply_request(input logic [1:0] func,
                                                  input logic [15:0] hid,
                                                  input logic [31:0] arg,
                                                  input logic [31:0] tmo,
                                                  input logic [3:0] idx);
    timer_result_t r;
    bit done;
    r = '0;
    done = 1'b0;
    case (func)
      FUNC_CREATE: begin
        r.status = STATUS_REJECT;
        if (hid != 16'd0 && tmo != 32'd0) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!done && !slot_busy[i]) begin
              done = 1'b1;
              slot_busy[i] = 1'b1;
              slot_ent[i] = '{deadline: ticks + tmo, handler: hid, arg: arg};
              r.status = STATUS_OK;
              r.slot = 4'(i);
            end
          end
        end
      end
      FUNC_DELETE: begin
        if (int'(idx) < NUM_SLOTS) slot_busy[idx] = 1'b0;
      end
      FUNC_TICK: begin
        ticks = ticks + 32'd1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!done && slot_busy[i] && slot_ent[i].deadline <= ticks) begin
            done = 1'b1;
            slot_busy[i] = 1'b0;
            r.slot = 4'(i);
            r.fired = 1'b1;
            r.fired_handler = slot_ent[i].handler;
            r.fired_arg = slot_ent[i].arg;
          end
        end
      end
      default: ;
    endcase
    r.tick_now = ticks;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_tally++;
    end
  endfunction

  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      ticks = '0;
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      due_results.delete();
    end else begin
      // results first: a result never belongs to a transaction taken at the same edge
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result with no transaction outstanding: slot %0d tick %0h", out_slot,
                 out_tick_now);
          fail_tally++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("slot", 32'(want.slot), 32'(out_slot));
          check_field("fired", 32'(want.fired), 32'(out_fired));
          check_field("fired_handler", 32'(want.fired_handler), 32'(out_fired_handler));
          check_field("fired_arg", want.fired_arg, out_fired_arg);
          check_field("tick_now", want.tick_now, out_tick_now);
        end
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(apply_request(in_func, in_handler_id, in_callback_arg,
                                            in_timeout, in_slot_index));
      end
    end
    mismatch_count <= fail_tally;
    outstanding <= due_results.size();
  end

endmodule

### bench/tb.sv
// testbench top for the one-shot timer table: clock, reset, stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ostt_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 500;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_START = 1500;
  localparam int HOLD_LEN = 300;
  localparam int QUIET_START = 2200;
  localparam int QUIET_END = 3000;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] handler_id;
    logic [31:0] callback_arg;
    logic [31:0] timeout;
    logic [3:0]  slot_index;
  } timer_req_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [15:0] in_handler_id;
  logic [31:0] in_callback_arg;
  logic [31:0] in_timeout;
  logic [3:0]  in_slot_index;
  logic        out_valid;
  logic        out_stall;
  logic        out_status;
  logic [3:0]  out_slot;
  logic        out_fired;
  logic [15:0] out_fired_handler;
  logic [31:0] out_fired_arg;
  logic [31:0] out_tick_now;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  int rx_cycle = 0;
  bit steady_sender = 1'b0;

  always #5 clk = ~clk;

  oneshot_software_timer_table_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_handler_id     (in_handler_id),
    .in_callback_arg   (in_callback_arg),
    .in_timeout        (in_timeout),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_fired         (out_fired),
    .out_fired_handler (out_fired_handler),
    .out_fired_arg     (out_fired_arg),
    .out_tick_now      (out_tick_now)
  );

  ostt_checker watch (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_handler_id     (in_handler_id),
    .in_callback_arg   (in_callback_arg),
    .in_timeout        (in_timeout),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_fired         (out_fired),
    .out_fired_handler (out_fired_handler),
    .out_fired_arg     (out_fired_arg),
    .out_tick_now      (out_tick_now),
    .mismatch_count    (fail_count),
    .outstanding       (outstanding)
  );

  function automatic timer_req_t make_req(input logic [1:0] func, input logic [15:0] hid,
                                          input logic [31:0] arg, input logic [31:0] tmo,
                                          input logic [3:0] idx);
    timer_req_t r;
    r.func = func;
    r.handler_id = hid;
    r.callback_arg = arg;
    r.timeout = tmo;
    r.slot_index = idx;
    return r;
  endfunction

  function automatic timer_req_t create_req();
    timer_req_t r;
    r.func = FUNC_CREATE;
    r.handler_id = ($urandom_range(0, 19) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
    r.callback_arg = $urandom;
    r.slot_index = 4'($urandom);
    case ($urandom_range(0, 19))
      0: r.timeout = '0;
      1: r.timeout = $urandom;
      2: r.timeout = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
      default: r.timeout = 32'($urandom_range(1, 40));
    endcase
    return r;
  endfunction

  function automatic timer_req_t random_req();
    timer_req_t r;
    int roll;
    r = make_req(2'($urandom), 16'($urandom), $urandom, $urandom, 4'($urandom));
    roll = $urandom_range(0, 99);
    if (roll < 40) r = create_req();
    else if (roll < 55) r.func = FUNC_DELETE;
    else if (roll < 95) r.func = FUNC_TICK;
    else r.func = FUNC_UNUSED;
    return r;
  endfunction

  task automatic offer(input timer_req_t req);
    int gap;
    gap = 0;
    if (!steady_sender && $urandom_range(0, 99) < 17) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= req.func;
    in_handler_id <= req.handler_id;
    in_callback_arg <= req.callback_arg;
    in_timeout <= req.timeout;
    in_slot_index <= req.slot_index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off and one stretch with no stalls
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
        out_stall <= 1'b1;
      end else if (rx_cycle >= QUIET_START && rx_cycle < QUIET_END) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 17);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    bit paused;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= '0;
    in_handler_id <= '0;
    in_callback_arg <= '0;
    in_timeout <= '0;
    in_slot_index <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rejected creates
    offer(make_req(FUNC_CREATE, 16'h0000, 32'h1234_5678, 32'd5, 4'd0));
    offer(make_req(FUNC_CREATE, 16'h00A5, 32'h8765_4321, 32'd0, 4'd0));
    // extreme values, fires on the next tick
    offer(make_req(FUNC_CREATE, 16'hFFFF, 32'hFFFF_FFFF, 32'd1, 4'hF));
    offer(make_req(FUNC_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
    // deadline wraps past zero and fires at once
    offer(make_req(FUNC_CREATE, 16'h8001, 32'h0000_0000, 32'hFFFF_FFFF, 4'd0));
    offer(make_req(FUNC_TICK, 16'h0000, 32'h0000_0000, 32'h0000_0000, 4'd0));
    // fill the table, slot 0 gets a deadline that is never reached
    for (int i = 0; i < 16; i++) begin
      offer(make_req(FUNC_CREATE, 16'(i + 1), $urandom,
                     (i == 0) ? 32'h8000_0000 : 32'(3 + 2 * i), 4'(i)));
    end
    offer(make_req(FUNC_CREATE, 16'h1234, 32'hDEAD_BEEF, 32'd7, 4'd0));
    offer(make_req(FUNC_DELETE, 16'h0000, 32'h0, 32'h0, 4'd5));
    offer(make_req(FUNC_DELETE, 16'h0000, 32'h0, 32'h0, 4'd5));
    offer(make_req(FUNC_CREATE, 16'h4321, 32'h5555_AAAA, 32'd9, 4'd0));
    offer(make_req(FUNC_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
    offer(make_req(FUNC_TICK, 16'h0000, 32'h0, 32'h0, 4'd0));

    n = 0;
    paused = 1'b0;
    while (n < RANDOM_ITEMS) begin
      steady_sender = (n >= 300 && n < 400);
      if (!paused && n >= 250) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 2) begin
        repeat (17) begin
          offer(create_req());
          n++;
        end
      end else begin
        offer(random_req());
        n++;
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/ostt_pkg.sv
rtl/ostt_ram.sv
rtl/oneshot_software_timer_table_top.sv
rtl/ostt_chk.sv
bench/ostt_checker.sv
bench/tb.sv
